FILE: rtl/tcf_pkg.sv
// Shared types, constants and lookup tables of the tile 3x3 convolution filter.
// Used by every module of the block but tcf_ram; depends on nothing else.
package tcf_pkg;

    localparam int TILE_W    = 32;
    localparam int TILE_H    = 32;
    localparam int LEVELS    = 256;
    localparam int TILE_SIZE = TILE_W * TILE_H;

    localparam int CW   = 5;
    localparam int PIXW = 8;
    localparam int XW   = $clog2(TILE_W);
    localparam int YW   = $clog2(TILE_H);
    localparam int AW   = $clog2(TILE_SIZE);
    localparam int IDXW = 6;
    localparam int TAPW = 4;
    localparam int KW   = 3;
    localparam int CFGIW = 1;

    localparam int ACC_W     = 13;
    localparam int NW        = 13;
    localparam int DIV_SHIFT = 19;
    localparam int RW        = 19;
    localparam int PW        = NW + RW;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_FILTER = 1'b1;

    localparam logic [CFGIW-1:0] CFG_KERNEL = 1'd0;
    localparam logic [CFGIW-1:0] CFG_WRAP   = 1'd1;

    localparam logic [KW-1:0] KSEL_SHARPEN = 3'd0;
    localparam logic          WRAP_ON      = 1'b1;

    typedef struct packed {
        logic            accept;
        logic            mem_we;
        logic            rd_en;
        logic [TAPW-1:0] tap;
        logic            acc_en;
        logic            acc_clr;
        logic            scale_en;
        logic            mul_en;
        logic            out_ld;
    } ctrl_t;

    typedef struct packed {
        logic out_busy;
    } stat_t;

    typedef logic [IDXW-1:0] cmap_t [64];

    // Entry i maps the neighbour coordinate i-1 into the tile.
    function automatic cmap_t build_map(input int size, input bit wrap);
        cmap_t m;
        int    w;
        w = 0;
        for (int i = 0; i < 64; i++) begin
            if (i == 0) begin
                m[i] = wrap ? IDXW'(size - 1) : '0;
            end
            else begin
                if (wrap) begin
                    m[i] = IDXW'(w);
                    w = (w + 1 == size) ? 0 : w + 1;
                end
                else begin
                    m[i] = (i - 1 >= size) ? IDXW'(size - 1) : IDXW'(i - 1);
                end
            end
        end
        return m;
    endfunction

    localparam cmap_t COL_WRAP  = build_map(TILE_W, 1'b1);
    localparam cmap_t COL_CLAMP = build_map(TILE_W, 1'b0);
    localparam cmap_t ROW_WRAP  = build_map(TILE_H, 1'b1);
    localparam cmap_t ROW_CLAMP = build_map(TILE_H, 1'b0);

    localparam logic [1:0] TAP_DX [0:8] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
                                            2'd0, 2'd1, 2'd2};
    localparam logic [1:0] TAP_DY [0:8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                            2'd2, 2'd2, 2'd2};

    localparam logic signed [4:0] KERN_W [0:7][0:8] = '{
        '{5'sd0, -5'sd2, 5'sd0, -5'sd2, 5'sd11, -5'sd2, 5'sd0, -5'sd2, 5'sd0},
        '{5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1},
        '{5'sd1, 5'sd2, 5'sd1, 5'sd2, 5'sd4, 5'sd2, 5'sd1, 5'sd2, 5'sd1},
        '{-5'sd1, -5'sd1, -5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd1, 5'sd1, 5'sd1},
        '{5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd0},
        '{5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd0},
        '{5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd0},
        '{5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd0}
    };

    // The result is (2*S*num + den) / (2*den), taken as a reciprocal product.
    localparam logic [2:0] KERN_NUM [0:7] = '{3'd1, 3'd1, 3'd1, 3'd1, 3'd5, 3'd5,
                                              3'd1, 3'd1};
    localparam logic [4:0] KERN_DEN [0:7] = '{5'd3, 5'd9, 5'd16, 5'd1, 5'd4, 5'd6,
                                              5'd1, 5'd1};
    localparam logic [RW-1:0] KERN_RECIP [0:7] = '{
        RW'((2**DIV_SHIFT + 5) / 6),
        RW'((2**DIV_SHIFT + 17) / 18),
        RW'((2**DIV_SHIFT) / 32),
        RW'((2**DIV_SHIFT) / 2),
        RW'((2**DIV_SHIFT) / 8),
        RW'((2**DIV_SHIFT + 11) / 12),
        RW'((2**DIV_SHIFT) / 2),
        RW'((2**DIV_SHIFT) / 2)
    };

endpackage

FILE: rtl/tcf_ram.sv
// Generic single-port RAM with registered read data.
// Self-contained; used for the pixel tile store.
module tcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        rdata_reg <= mem_array[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tcf_seq.sv
// Microcoded sequencer: step counter, control-word ROM and jump logic.
// Depends on tcf_pkg for the control and status structs.
module tcf_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_kind,
    output logic           in_ready,
    input  tcf_pkg::stat_t stat,
    output tcf_pkg::ctrl_t ctrl
);
    import tcf_pkg::*;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_RD0   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_RD8   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_ACC8  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_SCALE = 4'd11;
    localparam logic [STEP_W-1:0] STEP_MUL   = 4'd12;
    localparam logic [STEP_W-1:0] STEP_OUT   = 4'd13;
    localparam logic [STEP_W-1:0] STEP_WRITE = 4'd14;

    typedef enum logic [1:0] {
        JC_NEXT,
        JC_GOTO,
        JC_DISPATCH,
        JC_HOLD
    } jc_t;

    typedef struct packed {
        logic              ready;
        ctrl_t             ctrl;
        jc_t               jc;
        logic [STEP_W-1:0] tgt;
    } ucode_t;

    function automatic ucode_t uword(input logic [STEP_W-1:0] s);
        ucode_t w;
        w     = '0;
        w.jc  = JC_NEXT;
        w.tgt = STEP_IDLE;
        unique case (s) inside
            STEP_IDLE:
            begin
                w.ready        = 1'b1;
                w.ctrl.acc_clr = 1'b1;
                w.jc           = JC_DISPATCH;
                w.tgt          = STEP_WRITE;
            end
            [STEP_RD0:STEP_RD8]:
            begin
                w.ctrl.rd_en  = 1'b1;
                w.ctrl.tap    = TAPW'(s - STEP_RD0);
                w.ctrl.acc_en = (s != STEP_RD0);
            end
            STEP_ACC8:
            begin
                w.ctrl.acc_en = 1'b1;
            end
            STEP_SCALE:
            begin
                w.ctrl.scale_en = 1'b1;
            end
            STEP_MUL:
            begin
                w.ctrl.mul_en = 1'b1;
            end
            STEP_OUT:
            begin
                w.ctrl.out_ld = 1'b1;
                w.jc          = JC_HOLD;
                w.tgt         = STEP_IDLE;
            end
            STEP_WRITE:
            begin
                w.ctrl.mem_we = 1'b1;
                w.jc          = JC_GOTO;
                w.tgt         = STEP_IDLE;
            end
            default:
            begin
                w.jc  = JC_GOTO;
                w.tgt = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            uw;
    logic              accept;

    assign uw       = uword(step_reg);
    assign in_ready = uw.ready;
    assign accept   = uw.ready & in_valid;

    always_comb
    begin
        ctrl        = uw.ctrl;
        ctrl.accept = accept;
    end

    always_comb
    begin
        step_next = step_reg;
        unique case (uw.jc)
            JC_NEXT:     step_next = step_reg + 1'b1;
            JC_GOTO:     step_next = uw.tgt;
            JC_DISPATCH:
            begin
                if (accept)
                begin
                    step_next = (in_kind == KIND_LOAD) ? uw.tgt : step_reg + 1'b1;
                end
            end
            JC_HOLD:
            begin
                if (!stat.out_busy)
                begin
                    step_next = uw.tgt;
                end
            end
            default:     step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    a_load_goes_to_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_kind == KIND_LOAD) |=> step_reg == STEP_WRITE)
        else $error("load item did not reach the write step");

    a_filter_starts_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_kind == KIND_FILTER) |=> step_reg == STEP_RD0)
        else $error("filter item did not start the tap reads");

    a_out_release: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_OUT && !stat.out_busy) |=> step_reg == STEP_IDLE)
        else $error("sequencer did not return to idle after handing off a result");

endmodule

FILE: rtl/tcf_dp.sv
// Datapath: item latch, neighbour addressing, tile RAM, multiply-accumulate,
// reciprocal scaling, saturation and output register. Uses tcf_pkg and tcf_ram.
module tcf_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tcf_pkg::ctrl_t             ctrl,
    output tcf_pkg::stat_t             stat,
    input  logic [tcf_pkg::CW-1:0]     col,
    input  logic [tcf_pkg::CW-1:0]     row,
    input  logic [tcf_pkg::PIXW-1:0]   pixel_in,
    input  logic [tcf_pkg::KW-1:0]     kernel_sel,
    input  logic                       wrap_mode,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [tcf_pkg::CW-1:0]     out_col,
    output logic [tcf_pkg::CW-1:0]     out_row,
    output logic [tcf_pkg::PIXW-1:0]   filtered
);
    import tcf_pkg::*;

    logic [CW-1:0]          col_reg;
    logic [CW-1:0]          row_reg;
    logic [PIXW-1:0]        pix_reg;
    logic [TAPW-1:0]        tap_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic                   pos_reg;
    logic [NW-1:0]          num_reg;
    logic [NW-1:0]          num_next;
    logic [PW-1:0]          prod_reg;
    logic                   out_valid_reg;
    logic [CW-1:0]          out_col_reg;
    logic [CW-1:0]          out_row_reg;
    logic [PIXW-1:0]        out_pix_reg;

    logic [1:0]             dx;
    logic [1:0]             dy;
    logic [IDXW-1:0]        cidx;
    logic [IDXW-1:0]        ridx;
    logic [XW-1:0]          mx;
    logic [YW-1:0]          my;
    logic [AW-1:0]          addr;
    logic [PIXW-1:0]        rdata;
    logic signed [4:0]      wgt;
    logic signed [ACC_W-1:0] w_ext;
    logic signed [ACC_W-1:0] p_ext;
    logic signed [ACC_W-1:0] term;
    logic [NW-1:0]          quot;
    logic [PIXW-1:0]        result;
    logic                   out_busy;
    logic                   out_load;

    assign dx   = ctrl.mem_we ? 2'd1 : TAP_DX[ctrl.tap];
    assign dy   = ctrl.mem_we ? 2'd1 : TAP_DY[ctrl.tap];
    assign cidx = IDXW'({1'b0, col_reg}) + IDXW'(dx);
    assign ridx = IDXW'({1'b0, row_reg}) + IDXW'(dy);
    assign mx   = (wrap_mode == WRAP_ON) ? COL_WRAP[cidx][XW-1:0] : COL_CLAMP[cidx][XW-1:0];
    assign my   = (wrap_mode == WRAP_ON) ? ROW_WRAP[ridx][YW-1:0] : ROW_CLAMP[ridx][YW-1:0];
    assign addr = AW'(AW'(my) * AW'(TILE_W)) + AW'(mx);

    tcf_ram #(
        .WIDTH (PIXW),
        .DEPTH (TILE_SIZE)
    ) u_tile_ram (
        .clk   (clk),
        .we    (ctrl.mem_we),
        .addr  (addr),
        .wdata (pix_reg),
        .rdata (rdata)
    );

    // A zero weight selects zero so that a pixel never written adds nothing at that tap.
    assign wgt   = KERN_W[kernel_sel][tap_reg];
    assign w_ext = ACC_W'(wgt);
    assign p_ext = $signed(ACC_W'({1'b0, rdata}));
    assign term  = (wgt != 5'sd0) ? w_ext * p_ext : '0;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_next = acc_reg + term;
        end
    end

    assign num_next = NW'(NW'({acc_reg[ACC_W-2:0], 1'b0}) * NW'(KERN_NUM[kernel_sel]))
                    + NW'(KERN_DEN[kernel_sel]);

    assign quot   = prod_reg[PW-1 -: NW];
    assign result = !pos_reg ? '0 :
                    (quot > NW'(LEVELS - 1)) ? PIXW'(LEVELS - 1) : quot[PIXW-1:0];

    assign out_busy      = out_valid_reg & ~out_ready;
    assign out_load      = ctrl.out_ld & ~out_busy;
    assign stat.out_busy = out_busy;

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            col_reg <= col;
            row_reg <= row;
            pix_reg <= pixel_in;
        end
        if (ctrl.rd_en)
        begin
            tap_reg <= ctrl.tap;
        end
        acc_reg <= acc_next;
        if (ctrl.scale_en)
        begin
            pos_reg <= (acc_reg > 0);
            num_reg <= num_next;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= PW'(num_reg) * PW'(KERN_RECIP[kernel_sel]);
        end
        if (out_load)
        begin
            out_col_reg <= col_reg;
            out_row_reg <= row_reg;
            out_pix_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_load | out_busy;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign filtered  = out_pix_reg;

    a_result_from_ucode: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.out_ld))
        else $error("result appeared without an output step");

endmodule

FILE: rtl/tile_3x3_convolution_filter.sv
// Top level of the tile 3x3 convolution filter: configuration registers,
// sequencer and datapath. Depends on tcf_pkg, tcf_seq, tcf_dp and tcf_ram.
//
// Items arrive on the s_axis channel. tuser selects load (0) or filter (1).
// A load writes pixel_in at (col,row) of the 32x32 tile.
// A filter reads the nine neighbours one per cycle through the single port
// of the tile RAM, accumulates the weighted sum, scales it by a reciprocal
// product, rounds half up and saturates. Its result is registered on the
// m_axis channel after nine read steps, then the last accumulate, scale,
// multiply and output steps. The next item is taken as soon as the
// sequencer is back at its idle step, also while a result still waits in
// the output register. If the receiver stalls, the result holds, and a
// following filter item stops at its output step until the register is
// free.
// The configuration port writes kernel_select (index 0) and wrap_mode
// (index 1); write them only while the block is idle.
// Reset clears the sequencer, the output valid and the registers to
// sharpen with wrap; the tile contents are undefined until written.
module tile_3x3_convolution_filter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,  // col, row, pixel_in, zero pad
    input  logic                        s_axis_tuser,  // kind
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,  // out_col, out_row, filtered, zero pad
    input  logic                        cfg_we,
    input  logic [tcf_pkg::CFGIW-1:0]   cfg_index,
    input  logic [tcf_pkg::KW-1:0]      cfg_wdata
);
    import tcf_pkg::*;

    logic [KW-1:0]   kernel_reg;
    logic            wrap_reg;
    ctrl_t           ctrl;
    stat_t           stat;
    logic [CW-1:0]   out_col;
    logic [CW-1:0]   out_row;
    logic [PIXW-1:0] filtered;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= KSEL_SHARPEN;
            wrap_reg   <= WRAP_ON;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KERNEL: kernel_reg <= cfg_wdata;
                CFG_WRAP:   wrap_reg   <= cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    tcf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    tcf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .col        (s_axis_tdata[4:0]),
        .row        (s_axis_tdata[9:5]),
        .pixel_in   (s_axis_tdata[17:10]),
        .kernel_sel (kernel_reg),
        .wrap_mode  (wrap_reg),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_col    (out_col),
        .out_row    (out_row),
        .filtered   (filtered)
    );

    assign m_axis_tdata = {6'd0, filtered, out_row, out_col};

endmodule
